// ===== hdl/mtp_pkg.sv =====
package mtp_pkg;

  // generator geometry
  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_WORDS + 1);
  localparam int WORD_W       = 32;

  // recurrence and tempering constants
  localparam logic [WORD_W-1:0] TW_MATRIX    = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

  // command codes of a beat
  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_INIT,
    S_SEED_MUL,
    S_SEED_WR,
    S_TW_FIRST,
    S_TW_RD,
    S_TW_WR,
    S_DRAW_RD,
    S_DRAW_OUT
  } state_t;

  // read port a address source
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_POS
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    seed_init;
    logic    use_default;
    logic    seed_mul;
    logic    seed_wr;
    logic    tw_first;
    logic    tw_load_cur;
    logic    tw_wr;
    rd_sel_t rd_sel;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic pos_empty;
  } dp_stat_t;

endpackage

// ===== hdl/mtp_datapath.sv =====
module mtp_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mtp_pkg::dp_cmd_t            cmd,
  input  logic [mtp_pkg::WORD_W-1:0]  in_seed,
  output mtp_pkg::dp_stat_t           stat,
  output logic                        out_valid,
  output logic [mtp_pkg::WORD_W-1:0]  out_value
);

  localparam int IW = mtp_pkg::IDX_W;
  localparam int WW = mtp_pkg::WORD_W;

  // state word memory
  logic [WW-1:0] mem [mtp_pkg::STATE_WORDS];

  logic [WW-1:0] seed_r;
  logic [WW-1:0] prev_r, prev_nxt;
  logic [WW-1:0] prod_r;
  logic [WW-1:0] cur_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [WW-1:0] rd_a_q, rd_b_q;
  logic          out_valid_r;
  logic [WW-1:0] out_value_r;

  logic [IW-1:0] addr_a, addr_next, addr_far;
  logic [IW:0]   far_sum;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] seed_val, mix, seed_word, tw_y, tw_word;

  function automatic logic [WW-1:0] temper(input logic [WW-1:0] v);
    logic [WW-1:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & mtp_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtp_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // neighbor and far addresses of the word being twisted
  assign addr_next = (idx_r == IW'(mtp_pkg::STATE_WORDS - 1)) ? '0 : idx_r + 1'b1;
  assign far_sum   = {1'b0, idx_r} + (IW+1)'(mtp_pkg::SHIFT_OFFSET);
  assign addr_far  = (far_sum >= (IW+1)'(mtp_pkg::STATE_WORDS))
                   ? IW'(far_sum - (IW+1)'(mtp_pkg::STATE_WORDS))
                   : far_sum[IW-1:0];

  always_comb begin
    case (cmd.rd_sel)
      mtp_pkg::RD_ZERO: addr_a = '0;
      mtp_pkg::RD_NEXT: addr_a = addr_next;
      mtp_pkg::RD_POS:  addr_a = pos_r;
      default:          addr_a = '0;
    endcase
  end

  // seeding recurrence
  assign seed_val  = cmd.use_default ? mtp_pkg::DEFAULT_SEED : seed_r;
  assign mix       = prev_r ^ (prev_r >> 30);
  assign seed_word = prod_r + WW'(idx_r);

  // twist of one word
  assign tw_y    = {cur_r[WW-1], rd_a_q[WW-2:0]};
  assign tw_word = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? mtp_pkg::TW_MATRIX : '0);

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = seed_word;
    if (cmd.seed_init) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = seed_val;
    end else if (cmd.seed_wr) begin
      mem_we    = 1'b1;
    end else if (cmd.tw_wr) begin
      mem_we    = 1'b1;
      mem_wdata = tw_word;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_far];
  end

  // index, chain word and read position
  always_comb begin
    idx_nxt  = idx_r;
    prev_nxt = prev_r;
    pos_nxt  = pos_r;
    if (cmd.seed_init) begin
      idx_nxt  = IW'(1);
      prev_nxt = seed_val;
      pos_nxt  = IW'(mtp_pkg::STATE_WORDS);
    end else if (cmd.seed_wr) begin
      idx_nxt  = idx_r + 1'b1;
      prev_nxt = seed_word;
    end else if (cmd.tw_first) begin
      idx_nxt  = '0;
    end else if (cmd.tw_wr) begin
      idx_nxt  = idx_r + 1'b1;
      if (stat.idx_last) begin
        pos_nxt = '0;
      end
    end else if (cmd.out_load) begin
      pos_nxt  = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    prev_r <= prev_nxt;
    if (cmd.capture) begin
      seed_r <= in_seed;
    end
    if (cmd.seed_mul) begin
      prod_r <= WW'(mtp_pkg::INIT_MULT * mix);
    end
    if (cmd.tw_load_cur) begin
      cur_r <= rd_a_q;
    end
    if (cmd.out_load) begin
      out_value_r <= temper(rd_a_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= IW'(mtp_pkg::STATE_WORDS);
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= cmd.out_load;
    end
  end

  assign stat = '{idx_last:  (idx_r == IW'(mtp_pkg::STATE_WORDS - 1)),
                  pos_empty: (pos_r >= IW'(mtp_pkg::STATE_WORDS))};
  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;

endmodule

// ===== hdl/mtp_ctrl.sv =====
module mtp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_func,
  input  mtp_pkg::dp_stat_t  stat,
  output mtp_pkg::dp_cmd_t   cmd,
  output logic               busy
);

  mtp_pkg::state_t state_r, state_nxt;
  logic seeded_r, seeded_nxt;
  logic pend_r, pend_nxt;
  logic dflt_r, dflt_nxt;
  logic accept;

  assign accept = start && (state_r == mtp_pkg::S_IDLE);
  assign busy   = (state_r != mtp_pkg::S_IDLE);

  // state and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mtp_pkg::S_IDLE;
      seeded_r <= 1'b0;
      pend_r   <= 1'b0;
      dflt_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seeded_r <= seeded_nxt;
      pend_r   <= pend_nxt;
      dflt_r   <= dflt_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    seeded_nxt = seeded_r;
    pend_nxt   = pend_r;
    dflt_nxt   = dflt_r;
    cmd        = '0;
    cmd.rd_sel = mtp_pkg::RD_NEXT;
    case (state_r)
      mtp_pkg::S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_func == mtp_pkg::FUNC_RESEED) begin
            state_nxt = mtp_pkg::S_SEED_INIT;
            pend_nxt  = 1'b0;
            dflt_nxt  = 1'b0;
          end else if (!stat.pos_empty) begin
            state_nxt = mtp_pkg::S_DRAW_RD;
          end else if (!seeded_r) begin
            state_nxt = mtp_pkg::S_SEED_INIT;
            pend_nxt  = 1'b1;
            dflt_nxt  = 1'b1;
          end else begin
            state_nxt = mtp_pkg::S_TW_FIRST;
          end
        end
      end
      mtp_pkg::S_SEED_INIT: begin
        cmd.seed_init   = 1'b1;
        cmd.use_default = dflt_r;
        seeded_nxt      = 1'b1;
        state_nxt       = mtp_pkg::S_SEED_MUL;
      end
      mtp_pkg::S_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_nxt    = mtp_pkg::S_SEED_WR;
      end
      mtp_pkg::S_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        if (!stat.idx_last) begin
          state_nxt = mtp_pkg::S_SEED_MUL;
        end else if (pend_r) begin
          state_nxt = mtp_pkg::S_TW_FIRST;
        end else begin
          state_nxt = mtp_pkg::S_IDLE;
        end
      end
      mtp_pkg::S_TW_FIRST: begin
        cmd.tw_first = 1'b1;
        cmd.rd_sel   = mtp_pkg::RD_ZERO;
        state_nxt    = mtp_pkg::S_TW_RD;
      end
      mtp_pkg::S_TW_RD: begin
        cmd.tw_load_cur = 1'b1;
        state_nxt       = mtp_pkg::S_TW_WR;
      end
      mtp_pkg::S_TW_WR: begin
        cmd.tw_wr = 1'b1;
        state_nxt = stat.idx_last ? mtp_pkg::S_DRAW_RD : mtp_pkg::S_TW_RD;
      end
      mtp_pkg::S_DRAW_RD: begin
        cmd.rd_sel = mtp_pkg::RD_POS;
        pend_nxt   = 1'b0;
        state_nxt  = mtp_pkg::S_DRAW_OUT;
      end
      mtp_pkg::S_DRAW_OUT: begin
        cmd.rd_sel   = mtp_pkg::RD_POS;
        cmd.out_load = 1'b1;
        state_nxt    = mtp_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mtp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mersenne_twister_prng_core.sv =====
// 32-bit mt19937 generator with a 624-word state held in one memory.
// input beat: start is taken at a rising edge while busy is low, with
// in_func (0 draw, 1 reseed) and in_seed; busy then stays high until the
// beat is done. a reseed writes the whole state and gives no result; a draw
// gives one tempered word on out_value, marked by a one-cycle out_valid.
// a draw from a ready state word reads the word, then tempers it into the
// output register, which raises out_valid; the next start is taken in the
// strobe cycle, so one draw is through before the next one is taken.
// a reseed writes word 0 from the seed, then the other 623 words by the
// seeding recurrence, each as a registered 32x32 multiply, then an add and
// a write.
// after every 624 draws, and on the first draw after a reseed, the state is
// twisted in place before the read: word 0 is read, then each word has a read
// step and a write step on the two read ports and single write port.
// a draw before any reseed seeds with 5489 first, then twists.
// reset: synchronous, active low; clears control only, the state memory is
// not cleared and the next draw seeds it. the receiver cannot stall: each
// result is marked valid on out_valid for exactly one cycle.
module mersenne_twister_prng_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [mtp_pkg::WORD_W-1:0]  in_seed,
  output logic                        out_valid,
  output logic [mtp_pkg::WORD_W-1:0]  out_value
);

  mtp_pkg::dp_cmd_t  cmd;
  mtp_pkg::dp_stat_t stat;

  // sequencing
  mtp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // state memory, seeding, twist and tempering
  mtp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_seed   (in_seed),
    .stat      (stat),
    .out_valid (out_valid),
    .out_value (out_value)
  );

endmodule

// ===== test/mersenne_twister_prng_core_test.sv =====
module mersenne_twister_prng_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mtp_pkg::*;

  localparam int RANDOM_BEATS = 1150;
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int DRAIN_CYCLES = 8;

  // one row of the directed table; value is only used when known is set
  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] seed;
    logic              known;
    logic [WORD_W-1:0] value;
  } beat_row_t;

  localparam int DIRECTED_ROWS = 17;
  localparam beat_row_t DIRECTED [DIRECTED_ROWS] = '{
    // draws before any reseed run on the default seed
    '{FUNC_DRAW,   32'h0000_0000, 1'b1, 32'd3499211612},
    '{FUNC_DRAW,   32'hffff_ffff, 1'b1, 32'd581869302},
    '{FUNC_DRAW,   32'ha5a5_a5a5, 1'b0, 32'h0},
    // explicit default seed restarts the same stream
    '{FUNC_RESEED, DEFAULT_SEED,  1'b0, 32'h0},
    '{FUNC_DRAW,   32'h0000_0000, 1'b1, 32'd3499211612},
    '{FUNC_DRAW,   32'h5a5a_5a5a, 1'b1, 32'd581869302},
    // seed extremes
    '{FUNC_RESEED, 32'h0000_0000, 1'b0, 32'h0},
    '{FUNC_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{FUNC_DRAW,   32'hffff_ffff, 1'b0, 32'h0},
    '{FUNC_RESEED, 32'hffff_ffff, 1'b0, 32'h0},
    '{FUNC_DRAW,   32'h1234_5678, 1'b0, 32'h0},
    // back-to-back reseeds, last one wins
    '{FUNC_RESEED, 32'h8000_0000, 1'b0, 32'h0},
    '{FUNC_RESEED, 32'h0000_0001, 1'b0, 32'h0},
    '{FUNC_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{FUNC_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{FUNC_RESEED, 32'h7fff_ffff, 1'b0, 32'h0},
    '{FUNC_DRAW,   32'hffff_ffff, 1'b0, 32'h0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_func;
  logic [WORD_W-1:0] in_seed;
  logic              out_valid;
  logic [WORD_W-1:0] out_value;

  mersenne_twister_prng_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_func   (in_func),
    .in_seed   (in_seed),
    .out_valid (out_valid),
    .out_value (out_value)
  );

  always #2 clk = ~clk;

  // generator image kept alongside the block
  logic [WORD_W-1:0] mt_words [STATE_WORDS];
  int                mt_pos = STATE_WORDS;
  bit                mt_seeded = 1'b0;

  logic [WORD_W-1:0] expected_words [$];
  int                mismatches = 0;
  int                draws_sent = 0;
  int                reseeds_sent = 0;
  int                twists_done = 0;
  int                words_checked = 0;
  int                cycles = 0;
  int                burst_left = 0;
  bit                no_gaps = 1'b0;

  // knuth recurrence over the whole state
  function automatic void seed_words(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] p;
    mt_words[0] = s;
    for (int i = 1; i < STATE_WORDS; i++) begin
      p = mt_words[i-1];
      mt_words[i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
    end
    mt_pos    = STATE_WORDS;
    mt_seeded = 1'b1;
  endfunction

  // next tempered word, twisting in place when the state is used up
  function automatic logic [WORD_W-1:0] draw_word();
    logic [WORD_W-1:0] y;
    int nxt;
    int far_i;
    if (mt_pos >= STATE_WORDS) begin
      if (!mt_seeded) seed_words(DEFAULT_SEED);
      for (int i = 0; i < STATE_WORDS; i++) begin
        nxt   = (i + 1) % STATE_WORDS;
        far_i = (i + SHIFT_OFFSET) % STATE_WORDS;
        y = {mt_words[i][WORD_W-1], mt_words[nxt][WORD_W-2:0]};
        mt_words[i] = mt_words[far_i] ^ (y >> 1) ^ (y[0] ? TW_MATRIX : '0);
      end
      mt_pos = 0;
      twists_done++;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y ^= y >> 11;
    y ^= (y << 7) & TEMPER_B;
    y ^= (y << 15) & TEMPER_C;
    y ^= y >> 18;
    return y;
  endfunction

  // sender pacing: bursts of beats with random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  // drive one beat from a falling edge, hold until taken
  task automatic send_beat(input logic f, input logic [WORD_W-1:0] s,
                           input logic known, input logic [WORD_W-1:0] want);
    logic [WORD_W-1:0] w;
    in_func <= f;
    in_seed <= s;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (f == FUNC_RESEED) begin
      seed_words(s);
      reseeds_sent++;
    end else begin
      w = draw_word();
      expected_words.push_back(known ? want : w);
      draws_sent++;
    end
    @(negedge clk);
    pace();
  endtask

  // hold off until every pending draw has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : check_words
    logic [WORD_W-1:0] want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result with no draw pending: expected none, actual %h",
                 $time, out_value);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_value !== want) begin
          $display("%0t: out_value mismatch: expected %h, actual %h",
                   $time, want, out_value);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, expected_words.size());
      $display("mersenne_twister_prng_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    int run_len;
    int seg;
    int sent;
    logic [WORD_W-1:0] s;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_func = FUNC_DRAW;
    in_seed = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    no_gaps = 1'b1;
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      send_beat(DIRECTED[k].func, DIRECTED[k].seed, DIRECTED[k].known,
                DIRECTED[k].value);
    end
    wait_drained();
    @(negedge clk);

    // random segments: optional reseed, then a run of draws; some runs are
    // long enough to use up the state and force a twist mid-stream
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_BEATS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (seg != 0 && $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       s = '0;
          1:       s = '1;
          2:       s = DEFAULT_SEED;
          default: s = $urandom;
        endcase
        send_beat(FUNC_RESEED, s, 1'b0, '0);
        sent++;
      end
      run_len = (seg == 0 || $urandom_range(0, 9) == 0) ?
                $urandom_range(630, 700) : $urandom_range(0, 20);
      // keep the total near the planned beat count
      if (run_len > RANDOM_BEATS - sent) run_len = RANDOM_BEATS - sent;
      repeat (run_len) begin
        send_beat(FUNC_DRAW, $urandom, 1'b0, '0);
        sent++;
      end
      // now and then let everything drain before going on
      if ($urandom_range(0, 4) == 0) begin
        wait_drained();
        @(negedge clk);
      end
      seg++;
    end

    // drain and let any stray strobe show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d draws and %0d reseeds in %0d segments, %0d state twists",
             draws_sent, reseeds_sent, seg, twists_done);
    $display("%0d words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("mersenne_twister_prng_core_test: PASS");
    end else begin
      $display("mersenne_twister_prng_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mtp_pkg.sv
hdl/mtp_datapath.sv
hdl/mtp_ctrl.sv
hdl/mersenne_twister_prng_core.sv
test/mersenne_twister_prng_core_test.sv
